// ===== rtl/asdq_pkg.sv =====
package asdq_pkg;

	// field and register widths
	localparam int CODE_W    = 8;
	localparam int SAMPLE_W  = 16;
	localparam int WEIGHT_W  = 11;
	localparam int FLOOR_W   = 15;
	localparam int GAIN_W    = 16;
	localparam int LEAK_W    = 8;
	localparam int QB_W      = 4;
	localparam int REG_IDX_W = 3;
	localparam int WR_DATA_W = 16;

	// internal state widths
	localparam int STEP_W  = 27;  // step size <= 2^26
	localparam int POWER_W = 16;  // power <= 32768
	localparam int PRED_W  = 32;
	localparam int SUM_W   = PRED_W + 1;

	// shared multiplier
	localparam int MUL_A_W = SUM_W;
	localparam int MUL_B_W = POWER_W + 1;
	localparam int PROD_W  = MUL_A_W + MUL_B_W;

	// arithmetic constants
	localparam int AVG_SHIFT  = 10;  // weight is out of 1024
	localparam int LEAK_SHIFT = 5;   // leak is in 1/32 units
	localparam int STEP_EXTRA = 4;   // step shift is quant_bits + 4
	localparam int STEP_BASE  = 16;  // restart step is 1 << (16 - quant_bits)
	localparam int SEG_CAP    = (1 << 15) - 1;
	localparam int STEP_ACC_W = 32;
	localparam int ACC_W      = POWER_W + AVG_SHIFT + 2;
	localparam int PR_ACC_W   = SUM_W + LEAK_W + 1;
	localparam int PR_SH_W    = PR_ACC_W - LEAK_SHIFT;

	localparam logic [WEIGHT_W-1:0] WEIGHT_FULL = WEIGHT_W'(1 << AVG_SHIFT);

	// configuration reset values
	localparam logic [WEIGHT_W-1:0] AVG_WEIGHT_RST  = WEIGHT_W'(512);
	localparam logic [FLOOR_W-1:0]  POWER_FLOOR_RST = FLOOR_W'(1);
	localparam logic [GAIN_W-1:0]   STEP_GAIN_RST   = '0;
	localparam logic [LEAK_W-1:0]   LEAK_FACTOR_RST = '0;
	localparam logic [QB_W-1:0]     QUANT_BITS_RST  = QB_W'(4);

	// state reset values follow the configuration reset values
	localparam logic [STEP_W-1:0]  STEP_RST  = STEP_W'(1) << (STEP_BASE - 4);
	localparam logic [POWER_W-1:0] POWER_RST = POWER_W'(1);

	typedef enum logic [REG_IDX_W-1:0] {
		REG_AVG_WEIGHT  = 3'd0,
		REG_POWER_FLOOR = 3'd1,
		REG_STEP_GAIN   = 3'd2,
		REG_LEAK_FACTOR = 3'd3,
		REG_QUANT_BITS  = 3'd4
	} reg_idx_t;

	typedef struct packed {
		logic [WEIGHT_W-1:0] avg_weight;
		logic [FLOOR_W-1:0]  power_floor;
		logic [GAIN_W-1:0]   step_gain;
		logic [LEAK_W-1:0]   leak_factor;
		logic [QB_W-1:0]     quant_bits;
	} asdq_cfg_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MUL_DIFF,
		ST_CLAMP,
		ST_MUL_POW,
		ST_MUL_LEAK,
		ST_MUL_STEP,
		ST_FINISH,
		ST_SILENT
	} asdq_state_t;

	typedef enum logic [1:0] {
		MS_DIFF,
		MS_POW,
		MS_LEAK,
		MS_STEP
	} mul_sel_t;

	typedef struct packed {
		logic     capture;
		logic     restart;
		logic     mul_en;
		mul_sel_t mul_sel;
		logic     clamp_diff;
		logic     form_sum;
		logic     upd_power;
		logic     upd_pred;
		logic     commit;
		logic     emit_silent;
	} asdq_cmd_t;

	typedef struct packed {
		logic silent;
		logic out_free;
	} asdq_status_t;

endpackage

// ===== rtl/asdq_ctrl.sv =====
module asdq_ctrl (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   code_valid,
	input  logic                   op,
	input  asdq_pkg::asdq_status_t status,
	output logic                   code_stall,
	output asdq_pkg::asdq_cmd_t    cmd
);
	import asdq_pkg::*;

	asdq_state_t state_q;
	asdq_state_t state_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_comb begin
		state_nxt = state_q;
		case (state_q)
			ST_IDLE: begin
				if (code_valid && !op) begin
					state_nxt = status.silent ? ST_SILENT : ST_MUL_DIFF;
				end
			end
			ST_MUL_DIFF: state_nxt = ST_CLAMP;
			ST_CLAMP:    state_nxt = ST_MUL_POW;
			ST_MUL_POW:  state_nxt = ST_MUL_LEAK;
			ST_MUL_LEAK: state_nxt = ST_MUL_STEP;
			ST_MUL_STEP: state_nxt = ST_FINISH;
			ST_FINISH: begin
				if (status.out_free) begin
					state_nxt = ST_IDLE;
				end
			end
			ST_SILENT: begin
				if (status.out_free) begin
					state_nxt = ST_IDLE;
				end
			end
			default: state_nxt = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd        = '0;
		cmd.mul_sel = MS_DIFF;
		code_stall = (state_q != ST_IDLE);
		case (state_q)
			ST_IDLE: begin
				cmd.capture = code_valid && !op;
				cmd.restart = code_valid && op;
			end
			ST_MUL_DIFF: begin
				cmd.mul_en  = 1'b1;
				cmd.mul_sel = MS_DIFF;
			end
			ST_CLAMP: begin
				cmd.clamp_diff = 1'b1;
			end
			ST_MUL_POW: begin
				cmd.mul_en   = 1'b1;
				cmd.mul_sel  = MS_POW;
				cmd.form_sum = 1'b1;
			end
			ST_MUL_LEAK: begin
				cmd.mul_en    = 1'b1;
				cmd.mul_sel   = MS_LEAK;
				cmd.upd_power = 1'b1;
			end
			ST_MUL_STEP: begin
				cmd.mul_en   = 1'b1;
				cmd.mul_sel  = MS_STEP;
				cmd.upd_pred = 1'b1;
			end
			ST_FINISH: begin
				cmd.commit = status.out_free;
			end
			ST_SILENT: begin
				cmd.emit_silent = status.out_free;
			end
			default: begin
				cmd = '0;
			end
		endcase
	end

endmodule

// ===== rtl/asdq_datapath.sv =====
module asdq_datapath (
	input  logic                                clk,
	input  logic                                arst_n,
	input  asdq_pkg::asdq_cfg_t                 cfg,
	input  asdq_pkg::asdq_cmd_t                 cmd,
	input  logic signed [asdq_pkg::CODE_W-1:0]  code,
	input  logic                                segment_end,
	input  logic                                sample_stall,
	output asdq_pkg::asdq_status_t              status,
	output logic                                sample_valid,
	output logic signed [asdq_pkg::SAMPLE_W-1:0] sample,
	output logic                                last
);
	import asdq_pkg::*;

	localparam logic signed [PROD_W-1:0] PROD_HI =
		{{(PROD_W-SAMPLE_W+1){1'b0}}, {(SAMPLE_W-1){1'b1}}};
	localparam logic signed [PROD_W-1:0] PROD_LO =
		{{(PROD_W-SAMPLE_W+1){1'b1}}, {(SAMPLE_W-1){1'b0}}};
	localparam logic signed [SUM_W-1:0] SUM_HI =
		{{(SUM_W-SAMPLE_W+1){1'b0}}, {(SAMPLE_W-1){1'b1}}};
	localparam logic signed [SUM_W-1:0] SUM_LO =
		{{(SUM_W-SAMPLE_W+1){1'b1}}, {(SAMPLE_W-1){1'b0}}};
	localparam logic signed [PRED_W-1:0] PRED16_HI =
		{{(PRED_W-SAMPLE_W+1){1'b0}}, {(SAMPLE_W-1){1'b1}}};
	localparam logic signed [PRED_W-1:0] PRED16_LO =
		{{(PRED_W-SAMPLE_W+1){1'b1}}, {(SAMPLE_W-1){1'b0}}};
	localparam logic signed [PR_SH_W-1:0] PRED_HI =
		{{(PR_SH_W-PRED_W+1){1'b0}}, {(PRED_W-1){1'b1}}};
	localparam logic signed [PR_SH_W-1:0] PRED_LO =
		{{(PR_SH_W-PRED_W+1){1'b1}}, {(PRED_W-1){1'b0}}};
	localparam logic [POWER_W-1:0] POWER_CAP = POWER_W'(SEG_CAP);
	localparam logic [STEP_W-1:0]  STEP_CAP  = STEP_W'(SEG_CAP);

	// captured request
	logic signed [CODE_W-1:0] code_q;
	logic                     seg_q;

	// decoder state
	logic [STEP_W-1:0]         step_q;
	logic signed [PRED_W-1:0]  pred_q;
	logic [POWER_W-1:0]        power_q;

	// intermediates
	logic signed [PROD_W-1:0]   prod_q;
	logic signed [SAMPLE_W-1:0] diff_q;
	logic [POWER_W-1:0]         mag_q;
	logic signed [SUM_W-1:0]    sum_q;

	// output register
	logic                       out_valid_q;
	logic signed [SAMPLE_W-1:0] sample_q;
	logic                       last_q;

	logic [WEIGHT_W-1:0]        w_eff;
	logic signed [POWER_W:0]    pdm;
	logic signed [MUL_A_W-1:0]  mul_a;
	logic signed [MUL_B_W-1:0]  mul_b;
	logic signed [PROD_W-1:0]   mul_p;

	logic signed [SAMPLE_W-1:0] diff_c;
	logic [POWER_W-1:0]         mag_c;

	logic signed [ACC_W-1:0]    pw_acc;
	logic [POWER_W-1:0]         pw_rnd;
	logic [POWER_W-1:0]         pw_new;

	logic signed [PR_ACC_W-1:0] pr_acc;
	logic signed [PR_SH_W-1:0]  pr_sh;
	logic signed [PRED_W-1:0]   pr_new;

	logic [4:0]                 st_shamt;
	logic [STEP_ACC_W-1:0]      st_half;
	logic [STEP_ACC_W-1:0]      st_acc;
	logic [STEP_ACC_W-1:0]      st_sh;
	logic [STEP_W-1:0]          st_new;

	logic signed [SAMPLE_W-1:0] sample_c;
	logic signed [PRED_W-1:0]   pred_seg;
	logic [4:0]                 rst_shamt;

	assign w_eff = (cfg.avg_weight > WEIGHT_FULL) ? WEIGHT_FULL : cfg.avg_weight;
	// w*P + (1024-w)*mag == w*(P-mag) + 1024*mag: one product per update
	assign pdm   = $signed({1'b0, power_q}) - $signed({1'b0, mag_q});

	always_comb begin
		case (cmd.mul_sel)
			MS_DIFF: begin
				mul_a = {{(MUL_A_W-STEP_W){1'b0}}, step_q};
				mul_b = {{(MUL_B_W-CODE_W){code_q[CODE_W-1]}}, code_q};
			end
			MS_POW: begin
				mul_a = {{(MUL_A_W-POWER_W-1){pdm[POWER_W]}}, pdm};
				mul_b = {{(MUL_B_W-WEIGHT_W){1'b0}}, w_eff};
			end
			MS_LEAK: begin
				mul_a = sum_q;
				mul_b = {{(MUL_B_W-LEAK_W){1'b0}}, cfg.leak_factor};
			end
			MS_STEP: begin
				mul_a = {{(MUL_A_W-POWER_W){1'b0}}, power_q};
				mul_b = {{(MUL_B_W-GAIN_W){1'b0}}, cfg.step_gain};
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	assign mul_p = mul_a * mul_b;

	// difference: code*step clamped to 16 bits
	always_comb begin
		if (prod_q > PROD_HI) begin
			diff_c = PROD_HI[SAMPLE_W-1:0];
		end else if (prod_q < PROD_LO) begin
			diff_c = PROD_LO[SAMPLE_W-1:0];
		end else begin
			diff_c = prod_q[SAMPLE_W-1:0];
		end
		mag_c = diff_c[SAMPLE_W-1] ? POWER_W'(~diff_c + 1'b1) : POWER_W'(diff_c);
	end

	// power: rounded average, held at the floor
	always_comb begin
		pw_acc = $signed(prod_q[ACC_W-1:0])
			+ $signed({{(ACC_W-POWER_W-AVG_SHIFT){1'b0}}, mag_q, {AVG_SHIFT{1'b0}}})
			+ $signed(ACC_W'(1 << (AVG_SHIFT - 1)));
		pw_rnd = pw_acc[AVG_SHIFT +: POWER_W];
		pw_new = (pw_rnd < {1'b0, cfg.power_floor}) ? {1'b0, cfg.power_floor} : pw_rnd;
	end

	// prediction: rounded sum*leak/32, saturated to 32 bits
	always_comb begin
		pr_acc = $signed(prod_q[PR_ACC_W-1:0])
			+ $signed(PR_ACC_W'(1 << (LEAK_SHIFT - 1)));
		pr_sh  = pr_acc[PR_ACC_W-1:LEAK_SHIFT];
		if (pr_sh > PRED_HI) begin
			pr_new = PRED_HI[PRED_W-1:0];
		end else if (pr_sh < PRED_LO) begin
			pr_new = PRED_LO[PRED_W-1:0];
		end else begin
			pr_new = pr_sh[PRED_W-1:0];
		end
	end

	// step: rounded gain*power >> (quant_bits+4), never zero
	always_comb begin
		st_shamt = {1'b0, cfg.quant_bits} + 5'd4;
		st_half  = STEP_ACC_W'(1) << (st_shamt - 5'd1);
		st_acc   = prod_q[STEP_ACC_W-1:0] + st_half;
		st_sh    = st_acc >> st_shamt;
		st_new   = (st_sh[STEP_W-1:0] == '0) ? STEP_W'(1) : st_sh[STEP_W-1:0];
		if (seg_q && st_new > STEP_CAP) begin
			st_new = STEP_CAP;
		end
	end

	always_comb begin
		if (sum_q > SUM_HI) begin
			sample_c = SUM_HI[SAMPLE_W-1:0];
		end else if (sum_q < SUM_LO) begin
			sample_c = SUM_LO[SAMPLE_W-1:0];
		end else begin
			sample_c = sum_q[SAMPLE_W-1:0];
		end
		if (pred_q > PRED16_HI) begin
			pred_seg = PRED16_HI;
		end else if (pred_q < PRED16_LO) begin
			pred_seg = PRED16_LO;
		end else begin
			pred_seg = pred_q;
		end
	end

	assign rst_shamt = 5'(STEP_BASE) - {1'b0, cfg.quant_bits};

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			code_q <= code;
			seg_q  <= segment_end;
		end
		if (cmd.mul_en) begin
			prod_q <= mul_p;
		end
		if (cmd.clamp_diff) begin
			diff_q <= diff_c;
			mag_q  <= mag_c;
		end
		if (cmd.form_sum) begin
			sum_q <= {{(SUM_W-PRED_W){pred_q[PRED_W-1]}}, pred_q}
				+ {{(SUM_W-SAMPLE_W){diff_q[SAMPLE_W-1]}}, diff_q};
		end
		if (cmd.commit) begin
			sample_q <= sample_c;
			last_q   <= seg_q;
		end else if (cmd.emit_silent) begin
			sample_q <= '0;
			last_q   <= seg_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q  <= STEP_RST;
			pred_q  <= '0;
			power_q <= POWER_RST;
		end else if (cmd.restart) begin
			step_q  <= STEP_W'(1) << rst_shamt;
			pred_q  <= '0;
			power_q <= {1'b0, cfg.power_floor};
		end else if (cmd.upd_power) begin
			power_q <= pw_new;
		end else if (cmd.upd_pred) begin
			pred_q <= pr_new;
		end else if (cmd.commit) begin
			step_q <= st_new;
			if (seg_q) begin
				pred_q  <= pred_seg;
				power_q <= (power_q > POWER_CAP) ? POWER_CAP : power_q;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.commit || cmd.emit_silent) begin
			out_valid_q <= 1'b1;
		end else if (!sample_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	assign status.silent   = (cfg.quant_bits == '0);
	assign status.out_free = !out_valid_q || !sample_stall;

	assign sample_valid = out_valid_q;
	assign sample       = sample_q;
	assign last         = last_q;

endmodule

// ===== rtl/adaptive_subband_dequantiser_unit.sv =====
// Adaptive subband dequantiser for one subband. Each decode request carries a
// signed quantizer code; the block scales it by the current step size
// (clamped to 16 bits), updates the running power and step size, and returns
// the reconstructed sample (prediction plus difference, clamped to 16 bits)
// with last echoing segment_end. A restart request (op = 1) reloads step
// size, prediction and power from quant_bits and power_floor and returns
// nothing. With quant_bits = 0 the block returns zero samples and leaves its
// state alone. A decode request keeps the input stalled while the sequencer
// walks it through the single shared multiplier, which is used four times in
// a row (code*step, power average, sum*leak, gain*power) with a clamp state
// after the first use. A restart does not stall the input; a silent decode
// stalls it only until the output register is free. The finished sample sits
// in an output register, so the next request is taken while it waits; a
// decode only lingers in its finish state if the previous sample is still
// unclaimed. Registers are written through wr_en/wr_index/wr_data and must
// only change while the block is idle.
module adaptive_subband_dequantiser_unit (
	input  logic                                  clk,
	input  logic                                  arst_n,
	// register write port
	input  logic                                  wr_en,
	input  logic [asdq_pkg::REG_IDX_W-1:0]        wr_index,
	input  logic [asdq_pkg::WR_DATA_W-1:0]        wr_data,
	// request channel
	input  logic                                  code_valid,
	output logic                                  code_stall,
	input  logic                                  op,
	input  logic signed [asdq_pkg::CODE_W-1:0]    code,
	input  logic                                  segment_end,
	// sample channel
	output logic                                  sample_valid,
	input  logic                                  sample_stall,
	output logic signed [asdq_pkg::SAMPLE_W-1:0]  sample,
	output logic                                  last
);
	import asdq_pkg::*;

	asdq_cfg_t    cfg_q;
	asdq_cmd_t    cmd;
	asdq_status_t status;

	// configuration registers; unknown indexes are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.avg_weight  <= AVG_WEIGHT_RST;
			cfg_q.power_floor <= POWER_FLOOR_RST;
			cfg_q.step_gain   <= STEP_GAIN_RST;
			cfg_q.leak_factor <= LEAK_FACTOR_RST;
			cfg_q.quant_bits  <= QUANT_BITS_RST;
		end else if (wr_en) begin
			case (wr_index)
				REG_AVG_WEIGHT:  cfg_q.avg_weight  <= wr_data[WEIGHT_W-1:0];
				REG_POWER_FLOOR: cfg_q.power_floor <= wr_data[FLOOR_W-1:0];
				REG_STEP_GAIN:   cfg_q.step_gain   <= wr_data[GAIN_W-1:0];
				REG_LEAK_FACTOR: cfg_q.leak_factor <= wr_data[LEAK_W-1:0];
				REG_QUANT_BITS:  cfg_q.quant_bits  <= wr_data[QB_W-1:0];
				default: ;
			endcase
		end
	end

	// sequencer: walks one decode through the shared multiplier
	asdq_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.code_valid (code_valid),
		.op         (op),
		.status     (status),
		.code_stall (code_stall),
		.cmd        (cmd)
	);

	// state registers, multiplier, rounding/clamping and output register
	asdq_datapath u_datapath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg_q),
		.cmd          (cmd),
		.code         (code),
		.segment_end  (segment_end),
		.sample_stall (sample_stall),
		.status       (status),
		.sample_valid (sample_valid),
		.sample       (sample),
		.last         (last)
	);

	// a taken decode request always occupies the sequencer for the next cycle
	assert property (@(posedge clk) disable iff (!arst_n)
		(code_valid && !code_stall && !op) |=> code_stall)
		else $error("decode request taken but input not stalled next cycle");

	// a restart never produces a sample
	assert property (@(posedge clk) disable iff (!arst_n)
		(code_valid && !code_stall && op && !sample_valid) |=> !sample_valid)
		else $error("restart request produced a sample");

	// a new sample only appears out of a busy cycle
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(sample_valid) |-> $past(code_stall))
		else $error("sample appeared without a decode in flight");

endmodule
